// ----- src/sldf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Screen line framer package
// Shared kind codes, frame constants and the request and result payload types.
// ----------------------------------------------------------------------------
package sldf_pkg;

   typedef enum logic [2:0] {
      KIND_WRITE   = 3'd0,
      KIND_REFRESH = 3'd1,
      KIND_HOST    = 3'd2,
      KIND_CURSOR  = 3'd3,
      KIND_TABLE   = 3'd4,
      KIND_LOST    = 3'd5
   } kind_type;

   localparam logic [7:0] FRAME_MARK = 8'hFF;
   localparam int         FRAME_HEAD = 5;

   typedef struct packed {
      logic [2:0] kind;
      logic [4:0] cell_row;
      logic [6:0] cell_column;
      logic [7:0] cell_value;
      logic [7:0] table_index;
      logic [7:0] line_request;
      logic [7:0] cursor_row_in;
      logic [7:0] cursor_column_in;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte_a;
      logic [7:0] frame_byte_b;
      logic       byte_b_valid;
      logic       frame_last;
   } rsp_type;

endpackage
`default_nettype wire

// ----- src/sldf_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Screen line framer channel interfaces
// Valid/ready channels for requests and frame results.
// ----------------------------------------------------------------------------
interface sldf_req_if;
   logic              valid;
   logic              ready;
   sldf_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface sldf_rsp_if;
   logic              valid;
   logic              ready;
   sldf_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/screen_line_diff_framer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Screen line difference framer
// Keeps wanted and sent cell images and frames the changed span of a line.
// ----------------------------------------------------------------------------
// Channel   Direction  Carries
// req       in         one update, write, load or status transaction
// rsp       out        up to two frame bytes per transaction
//
// Cells live in memories with a separate write port and a registered read;
// one shared compare unit walks a row column by column.
// A line update scans the row for the changed span, then sends the
// five-byte frame head and then each cell of the span.
// After reset a clearing pass walks both images, and on each first cursor
// status the sent image; no transaction is accepted during the pass.
// A stalled result holds the sequencer.
// ----------------------------------------------------------------------------
module screen_line_diff_framer #(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input  wire logic clock,
   input  wire logic reset,
   sldf_req_if.sink   req,
   sldf_rsp_if.source rsp
);

   localparam int DEPTH = ROWS * COLS;
   localparam int AW    = $clog2(DEPTH + 1);
   localparam int RW    = $clog2(ROWS + 1);
   localparam int CW    = $clog2(COLS + 1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_ENDRD, S_ENDCMP, S_STRD, S_STCMP,
      S_HEAD, S_CPRD, S_CPWR, S_OUT, S_WAIT
   } state_type;

   state_type       state_ff;
   logic [AW-1:0]   clr_ff;
   logic [RW-1:0]   line_ff, cur_row_ff, crow_ff;
   logic [CW-1:0]   ccol_ff;
   logic [CW-1:0]   end_ff, start_ff, idx_ff;
   logic            force_ff, rdy_ff;
   logic [2:0]      hpos_ff;
   logic            half_ff;
   logic [7:0]      pend_ff;
   sldf_pkg::rsp_type rsp_ff;
   logic            rspv_ff;

   logic [7:0] want_mem [DEPTH];
   logic [7:0] sent_mem [DEPTH];
   logic [7:0] xlat_mem [256];
   logic [7:0] want_q, sent_q, xlat_q;

   logic [AW-1:0] rd_addr;
   logic          sent_we;
   logic [AW-1:0] sent_wa;
   logic [7:0]    sent_wd;
   logic [AW-1:0] row_base;

   sldf_pkg::req_type rq;
   assign rq = req.data;

   assign row_base = AW'(line_ff) * AW'(COLS);

   // clamp helpers
   logic [RW-1:0] r_clamp;
   logic [CW-1:0] c_clamp;
   always_comb begin
      if (rq.cursor_row_in == 8'd0)
         r_clamp = '0;
      else if (32'(rq.cursor_row_in) > ROWS)
         r_clamp = RW'(ROWS - 1);
      else
         r_clamp = RW'(rq.cursor_row_in - 8'd1);
      if (rq.cursor_column_in == 8'd0)
         c_clamp = '0;
      else if (32'(rq.cursor_column_in) > COLS)
         c_clamp = CW'(COLS - 1);
      else
         c_clamp = CW'(rq.cursor_column_in - 8'd1);
   end

   always_comb begin
      case (state_ff)
         S_ENDRD:  rd_addr = row_base + AW'(end_ff - CW'(1));
         S_STRD:   rd_addr = row_base + AW'(start_ff);
         default:  rd_addr = row_base + AW'(idx_ff);
      endcase
   end

   // memories
   logic          want_we;
   logic [AW-1:0] want_wa;
   logic [7:0]    want_wd;
   assign want_we = ((state_ff == S_CLEAR) && !rdy_ff)
                    || ((state_ff == S_IDLE) && req.valid && req.ready
                        && rq.kind == sldf_pkg::KIND_WRITE
                        && 32'(rq.cell_row) < ROWS && 32'(rq.cell_column) < COLS);
   assign want_wa = (state_ff == S_CLEAR) ? clr_ff
                    : AW'(rq.cell_row) * AW'(COLS) + AW'(rq.cell_column);
   assign want_wd = (state_ff == S_CLEAR) ? 8'd0 : rq.cell_value;

   always_ff @(posedge clock) begin
      if (want_we)
         want_mem[want_wa] <= want_wd;
      want_q <= want_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (sent_we)
         sent_mem[sent_wa] <= sent_wd;
      sent_q <= sent_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_IDLE) && req.valid && req.ready
          && rq.kind == sldf_pkg::KIND_TABLE)
         xlat_mem[rq.table_index] <= rq.cell_value;
      xlat_q <= xlat_mem[want_q];
   end

   always_comb begin
      sent_we = 1'b0;
      sent_wa = row_base + AW'(idx_ff);
      sent_wd = want_q;
      if (state_ff == S_CLEAR) begin
         sent_we = 1'b1;
         sent_wa = clr_ff;
         sent_wd = 8'd0;
      end else if (state_ff == S_CPWR) begin
         sent_we = 1'b1;
      end
   end

   assign req.ready = (state_ff == S_IDLE) && !rspv_ff;
   assign rsp.valid = rspv_ff;
   assign rsp.data  = rsp_ff;

   // head byte for position hpos_ff
   logic [7:0] head_byte;
   always_comb begin
      case (hpos_ff)
         3'd0:    head_byte = sldf_pkg::FRAME_MARK;
         3'd1:    head_byte = 8'(line_ff) + 8'd1;
         3'd2:    head_byte = (line_ff == crow_ff) ? 8'(ccol_ff) + 8'd1 : 8'd0;
         3'd3:    head_byte = 8'(start_ff) + 8'd1;
         default: head_byte = 8'(end_ff - start_ff);
      endcase
   end

   logic rsp_free;
   assign rsp_free = !rspv_ff || rsp.ready;

   logic rsp_load;
   always_comb begin
      case (state_ff)
         S_HEAD:  rsp_load = half_ff && rsp_free;
         S_OUT:   rsp_load = rsp_free && (start_ff == end_ff || half_ff
                                          || idx_ff + CW'(1) == end_ff);
         default: rsp_load = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_ff     <= '0;
         rspv_ff    <= 1'b0;
         rdy_ff     <= 1'b0;
         line_ff    <= '0;
         cur_row_ff <= '0;
         crow_ff    <= '0;
         ccol_ff    <= '0;
         half_ff    <= 1'b0;
      end else begin
         if (rsp_load)
            rspv_ff <= 1'b1;
         else if (rspv_ff && rsp.ready)
            rspv_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               if (clr_ff == AW'(DEPTH - 1)) begin
                  clr_ff <= '0;
                  line_ff <= crow_ff;
                  state_ff <= rdy_ff ? S_ENDRD : S_IDLE;
               end else begin
                  clr_ff <= clr_ff + AW'(1);
               end
            end
            S_IDLE: begin
               end_ff   <= CW'(COLS);
               start_ff <= '0;
               if (req.valid && req.ready) begin
                  case (rq.kind)
                     sldf_pkg::KIND_REFRESH: begin
                        force_ff <= 1'b0;
                        line_ff  <= cur_row_ff;
                        if (rdy_ff)
                           state_ff <= S_ENDRD;
                     end
                     sldf_pkg::KIND_HOST: begin
                        if (rq.line_request == 8'd0) begin
                           force_ff <= 1'b1;
                           line_ff  <= crow_ff;
                           state_ff <= S_ENDRD;
                        end else if (32'(rq.line_request) <= ROWS) begin
                           force_ff   <= 1'b0;
                           line_ff    <= RW'(rq.line_request - 8'd1);
                           cur_row_ff <= RW'(rq.line_request - 8'd1);
                           state_ff   <= S_ENDRD;
                        end
                     end
                     sldf_pkg::KIND_CURSOR: begin
                        force_ff <= 1'b1;
                        if (!rdy_ff) begin
                           rdy_ff     <= 1'b1;
                           cur_row_ff <= r_clamp;
                           crow_ff    <= r_clamp;
                           ccol_ff    <= c_clamp;
                           state_ff   <= S_CLEAR;
                        end else if (r_clamp != crow_ff || c_clamp != ccol_ff) begin
                           crow_ff  <= r_clamp;
                           ccol_ff  <= c_clamp;
                           line_ff  <= r_clamp;
                           state_ff <= S_ENDRD;
                        end
                     end
                     sldf_pkg::KIND_LOST: rdy_ff <= 1'b0;
                     default: ;
                  endcase
               end
            end
            S_ENDRD: begin
               if (end_ff == '0) begin
                  state_ff <= S_STRD;
               end else begin
                  state_ff <= S_ENDCMP;
               end
            end
            S_ENDCMP: begin
               if (want_q == sent_q) begin
                  end_ff   <= end_ff - CW'(1);
                  state_ff <= S_ENDRD;
               end else begin
                  state_ff <= S_STRD;
               end
            end
            S_STRD: begin
               if (start_ff >= end_ff) begin
                  if (!force_ff && end_ff == start_ff)
                     state_ff <= S_IDLE;
                  else begin
                     state_ff <= S_HEAD;
                     hpos_ff  <= '0;
                     half_ff  <= 1'b0;
                  end
               end else begin
                  state_ff <= S_STCMP;
               end
            end
            S_STCMP: begin
               if (want_q == sent_q) begin
                  start_ff <= start_ff + CW'(1);
                  state_ff <= S_STRD;
               end else begin
                  state_ff <= S_HEAD;
                  hpos_ff  <= '0;
                  half_ff  <= 1'b0;
               end
            end
            S_HEAD: begin
               idx_ff <= start_ff;
               if (!half_ff) begin
                  pend_ff <= head_byte;
                  half_ff <= 1'b1;
                  hpos_ff <= hpos_ff + 3'd1;
               end else if (rsp_free) begin
                  rsp_ff.frame_byte_a <= pend_ff;
                  rsp_ff.frame_byte_b <= head_byte;
                  rsp_ff.byte_b_valid <= 1'b1;
                  rsp_ff.frame_last   <= 1'b0;
                  half_ff <= 1'b0;
                  hpos_ff <= hpos_ff + 3'd1;
               end
               if (hpos_ff == 3'd4 && !half_ff) begin
                  // fifth byte becomes the first of the next pair
                  if (start_ff == end_ff) begin
                     state_ff <= S_OUT;
                  end else begin
                     state_ff <= S_CPRD;
                  end
               end
            end
            S_CPRD: state_ff <= S_CPWR;
            S_CPWR: state_ff <= S_WAIT;
            S_WAIT: state_ff <= S_OUT;
            S_OUT: begin
               if (rsp_free) begin
                  if (start_ff == end_ff) begin
                     rsp_ff.frame_byte_a <= pend_ff;
                     rsp_ff.frame_byte_b <= 8'd0;
                     rsp_ff.byte_b_valid <= 1'b0;
                     rsp_ff.frame_last   <= 1'b1;
                     state_ff <= S_IDLE;
                  end else if (half_ff) begin
                     rsp_ff.frame_byte_a <= pend_ff;
                     rsp_ff.frame_byte_b <= xlat_q;
                     rsp_ff.byte_b_valid <= 1'b1;
                     rsp_ff.frame_last   <= (idx_ff + CW'(1) == end_ff);
                     half_ff <= 1'b0;
                     if (idx_ff + CW'(1) == end_ff)
                        state_ff <= S_IDLE;
                     else begin
                        idx_ff   <= idx_ff + CW'(1);
                        state_ff <= S_CPRD;
                     end
                  end else begin
                     pend_ff <= xlat_q;
                     half_ff <= 1'b1;
                     if (idx_ff + CW'(1) == end_ff) begin
                        rsp_ff.frame_byte_a <= xlat_q;
                        rsp_ff.frame_byte_b <= 8'd0;
                        rsp_ff.byte_b_valid <= 1'b0;
                        rsp_ff.frame_last   <= 1'b1;
                        state_ff <= S_IDLE;
                     end else begin
                        idx_ff   <= idx_ff + CW'(1);
                        state_ff <= S_CPRD;
                     end
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rspv_ff && !rsp.ready |=> rspv_ff && $stable(rsp_ff);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("result changed while stalled");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == S_IDLE)
      else $error("request accepted while busy");

   a_span_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT |-> start_ff <= end_ff)
      else $error("span start beyond end");
`endif

endmodule
`default_nettype wire
